FILE: sv/ffsa_pkg.sv
// Shared types, operation codes and helpers for the first-fit segment allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffsa_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t length;
        word_t start;
    } seg_t;

    localparam int SEG_W = $bits(seg_t);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [3:0] OP_IDLE      = 4'd0;
    localparam logic [3:0] OP_INIT      = 4'd1;
    localparam logic [3:0] OP_LOAD      = 4'd2;
    localparam logic [3:0] OP_SCAN      = 4'd3;
    localparam logic [3:0] OP_DECIDE    = 4'd4;
    localparam logic [3:0] OP_SHIFT_DN  = 4'd5;
    localparam logic [3:0] OP_SHIFT_UP  = 4'd6;
    localparam logic [3:0] OP_WR_SHRINK = 4'd7;
    localparam logic [3:0] OP_WR_PREV   = 4'd8;
    localparam logic [3:0] OP_WR_NEXT   = 4'd9;
    localparam logic [3:0] OP_WR_NEW    = 4'd10;
    localparam logic [3:0] OP_REMOVE    = 4'd11;
    localparam logic [3:0] OP_RESULT    = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic is_free;
        logic exact;
        logic mprev;
        logic mnext;
        logic full;
        logic dn_done;
        logic up_done;
    } stat_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

endpackage

FILE: sv/ffsa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package needed.
module ffsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/ffsa_dp.sv
// Datapath of the segment allocator: segment table RAM, scan and shift pointers,
// merge arithmetic and result registers. Depends on ffsa_pkg and ffsa_ram.
module ffsa_dp
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_kind,
    input  logic [31:0] in_size,
    input  logic [31:0] in_offset,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [31:0] res_offset,
    output logic [31:0] res_size,
    output logic [1:0]  res_status
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_idx_reg, pend_idx_next;
    logic          found_reg, found_next;
    logic          prev_ok_reg, prev_ok_next;
    logic [CW-1:0] hit_reg, hit_next;
    seg_t          cur_reg, cur_next;
    seg_t          prev_reg, prev_next;
    logic          kind_reg, kind_next;
    word_t         size_reg, size_next;
    word_t         off_reg, off_next;
    word_t         acc_reg, acc_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic          sh_pend_reg, sh_pend_next;
    logic [AW-1:0] sh_addr_reg, sh_addr_next;
    logic [1:0]    gst_reg, gst_next;
    word_t         out_ofs_reg, out_ofs_next;
    word_t         out_size_reg, out_size_next;
    logic [1:0]    out_st_reg, out_st_next;

    logic             we;
    logic [AW-1:0]    waddr;
    seg_t             wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [SEG_W-1:0] rdata_raw;
    seg_t             rd_seg;

    logic [32:0]   end_w;
    logic [32:0]   prev_end;
    logic          mprev;
    logic          mnext;
    logic          hit_cond;
    logic          down;
    logic [CW-1:0] sh_dec;
    logic [CW-1:0] hit_dec;

    ffsa_ram #(
        .WIDTH(SEG_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .clk    (aclk),
        .wr_en  (we),
        .wr_addr(waddr),
        .wr_data(wdata),
        .rd_en  (re),
        .rd_addr(raddr),
        .rd_data(rdata_raw)
    );

    assign rd_seg   = rdata_raw;
    assign end_w    = {1'b0, off_reg} + {1'b0, size_reg};
    assign prev_end = {1'b0, prev_reg.start} + {1'b0, prev_reg.length};
    assign mprev    = prev_ok_reg && (prev_end == {1'b0, off_reg});
    assign mnext    = found_reg && (end_w == {1'b0, cur_reg.start});
    assign hit_cond = kind_reg ? (end_w <= {1'b0, rd_seg.start}) : (rd_seg.length >= size_reg);
    assign down     = !kind_reg || (mprev && mnext);
    assign sh_dec   = sh_reg - 1'b1;
    assign hit_dec  = hit_reg - 1'b1;

    assign stat.scan_done = found_reg || (!pend_reg && !(idx_reg < count_reg));
    assign stat.found     = found_reg;
    assign stat.is_free   = kind_reg;
    assign stat.exact     = (cur_reg.length == size_reg);
    assign stat.mprev     = mprev;
    assign stat.mnext     = mnext;
    assign stat.full      = (count_reg >= CNT_MAX);
    assign stat.dn_done   = !sh_pend_reg && !(sh_reg < count_reg);
    assign stat.up_done   = !sh_pend_reg && !(sh_reg > hit_reg);

    always_comb begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        prev_ok_next  = prev_ok_reg;
        hit_next      = hit_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        kind_next     = kind_reg;
        size_next     = size_reg;
        off_next      = off_reg;
        acc_next      = acc_reg;
        sh_next       = sh_reg;
        sh_pend_next  = sh_pend_reg;
        sh_addr_next  = sh_addr_reg;
        gst_next      = gst_reg;
        out_ofs_next  = out_ofs_reg;
        out_size_next = out_size_reg;
        out_st_next   = out_st_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;

        unique case (cmd.op)
            OP_INIT: begin
                we = 1'b1;
            end
            OP_LOAD: begin
                kind_next    = in_kind;
                size_next    = in_size;
                off_next     = in_offset;
                idx_next     = '0;
                pend_next    = 1'b0;
                found_next   = 1'b0;
                prev_ok_next = 1'b0;
                hit_next     = '0;
            end
            OP_SCAN: begin
                pend_next = 1'b0;
                if (!found_reg && (idx_reg < count_reg)) begin
                    re            = 1'b1;
                    raddr         = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                end
                if (!found_reg && pend_reg) begin
                    if (hit_cond) begin
                        found_next = 1'b1;
                        hit_next   = pend_idx_reg;
                        cur_next   = rd_seg;
                    end else begin
                        prev_next    = rd_seg;
                        prev_ok_next = 1'b1;
                        hit_next     = pend_idx_reg + 1'b1;
                    end
                end
            end
            OP_DECIDE: begin
                acc_next     = sat_add(prev_reg.length, size_reg);
                sh_next      = down ? hit_reg + 1'b1 : count_reg;
                sh_pend_next = 1'b0;
                if (!kind_reg) begin
                    gst_next = found_reg ? ST_OK : ST_NOSPACE;
                end else if (!mprev && !mnext && (count_reg >= CNT_MAX)) begin
                    gst_next = ST_FULL;
                end else begin
                    gst_next = ST_OK;
                end
            end
            OP_SHIFT_DN: begin
                sh_pend_next = 1'b0;
                if (sh_reg < count_reg) begin
                    re           = 1'b1;
                    raddr        = sh_reg[AW-1:0];
                    sh_addr_next = sh_dec[AW-1:0];
                    sh_next      = sh_reg + 1'b1;
                    sh_pend_next = 1'b1;
                end
                if (sh_pend_reg) begin
                    we    = 1'b1;
                    waddr = sh_addr_reg;
                    wdata = rd_seg;
                end
            end
            OP_SHIFT_UP: begin
                sh_pend_next = 1'b0;
                if (sh_reg > hit_reg) begin
                    re           = 1'b1;
                    raddr        = sh_dec[AW-1:0];
                    sh_addr_next = sh_reg[AW-1:0];
                    sh_next      = sh_dec;
                    sh_pend_next = 1'b1;
                end
                if (sh_pend_reg) begin
                    we    = 1'b1;
                    waddr = sh_addr_reg;
                    wdata = rd_seg;
                end
            end
            OP_WR_SHRINK: begin
                we           = 1'b1;
                waddr        = hit_reg[AW-1:0];
                wdata.start  = cur_reg.start + size_reg;
                wdata.length = cur_reg.length - size_reg;
            end
            OP_WR_PREV: begin
                we           = 1'b1;
                waddr        = hit_dec[AW-1:0];
                wdata.start  = prev_reg.start;
                wdata.length = mnext ? sat_add(acc_reg, cur_reg.length) : acc_reg;
            end
            OP_WR_NEXT: begin
                we           = 1'b1;
                waddr        = hit_reg[AW-1:0];
                wdata.start  = off_reg;
                wdata.length = sat_add(cur_reg.length, size_reg);
            end
            OP_WR_NEW: begin
                we           = 1'b1;
                waddr        = hit_reg[AW-1:0];
                wdata.start  = off_reg;
                wdata.length = size_reg;
                count_next   = count_reg + 1'b1;
            end
            OP_REMOVE: begin
                count_next = count_reg - 1'b1;
            end
            OP_RESULT: begin
                out_ofs_next  = (!kind_reg && found_reg) ? cur_reg.start : '0;
                out_size_next = (!kind_reg && found_reg) ? size_reg : '0;
                out_st_next   = gst_reg;
            end
            default: begin
            end
        endcase

        // A register write rebuilds the table as one segment over the whole buffer.
        if (cfg_wr_en) begin
            we           = 1'b1;
            waddr        = '0;
            wdata.start  = '0;
            wdata.length = cfg_wr_data;
            count_next   = CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= CW'(1);
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            prev_ok_reg <= 1'b0;
            hit_reg     <= '0;
            sh_reg      <= '0;
            sh_pend_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            prev_ok_reg <= prev_ok_next;
            hit_reg     <= hit_next;
            sh_reg      <= sh_next;
            sh_pend_reg <= sh_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        kind_reg     <= kind_next;
        size_reg     <= size_next;
        off_reg      <= off_next;
        acc_reg      <= acc_next;
        sh_addr_reg  <= sh_addr_next;
        gst_reg      <= gst_next;
        out_ofs_reg  <= out_ofs_next;
        out_size_reg <= out_size_next;
        out_st_reg   <= out_st_next;
    end

    assign res_offset = out_ofs_reg;
    assign res_size   = out_size_reg;
    assign res_status = out_st_reg;

endmodule

FILE: sv/ffsa_ctrl.sv
// Controller state machine of the segment allocator: sequences scan, decision,
// table shifts and writes, and owns both handshakes. Depends on ffsa_pkg.
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_SHRINK = 4'd4;
    localparam logic [3:0] S_WPREV  = 4'd5;
    localparam logic [3:0] S_WNEXT  = 4'd6;
    localparam logic [3:0] S_SHDN   = 4'd7;
    localparam logic [3:0] S_SHUP   = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = OP_IDLE;

        unique case (state_reg)
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_DECIDE;
                end else begin
                    cmd.op = OP_SCAN;
                end
            end
            S_DECIDE: begin
                cmd.op = OP_DECIDE;
                if (!stat.is_free) begin
                    if (!stat.found) begin
                        state_next = S_RESULT;
                    end else if (stat.exact) begin
                        state_next = S_SHDN;
                    end else begin
                        state_next = S_SHRINK;
                    end
                end else if (stat.mprev) begin
                    state_next = S_WPREV;
                end else if (stat.mnext) begin
                    state_next = S_WNEXT;
                end else if (stat.full) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_SHUP;
                end
            end
            S_SHRINK: begin
                cmd.op     = OP_WR_SHRINK;
                state_next = S_RESULT;
            end
            S_WPREV: begin
                cmd.op     = OP_WR_PREV;
                state_next = stat.mnext ? S_SHDN : S_RESULT;
            end
            S_WNEXT: begin
                cmd.op     = OP_WR_NEXT;
                state_next = S_RESULT;
            end
            S_SHDN: begin
                if (stat.dn_done) begin
                    cmd.op     = OP_REMOVE;
                    state_next = S_RESULT;
                end else begin
                    cmd.op = OP_SHIFT_DN;
                end
            end
            S_SHUP: begin
                if (stat.up_done) begin
                    cmd.op     = OP_WR_NEW;
                    state_next = S_RESULT;
                end else begin
                    cmd.op = OP_SHIFT_UP;
                end
            end
            S_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

FILE: sv/first_fit_segment_allocator.sv
// Channel    Direction  Handshake          Payload
// cfg        in         cfg_wr_en          cfg_wr_data = buffer_size
// request    in         s_tvalid/s_tready  s_tuser = kind, s_tdata = req_size, req_offset
// result     out        m_tvalid/m_tready  m_tdata = grant_offset, grant_size, status
//
// The free table sits in one RAM and is scanned one entry per cycle; the scan reads at most
// all N entries and stops on a match. Removing or inserting a segment shifts the entries
// behind it down or up one at a time in S_SHDN or S_SHUP, then updates the count.
// After reset the S_INIT state writes an empty segment (start and length zero) to entry 0 before s_tready rises.
// A finished result waits in the output register while the next item is accepted.
// Top level of the first-fit segment allocator; depends on ffsa_pkg, ffsa_ctrl, ffsa_dp.
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // req_size [31:0], req_offset [63:32]
    input  logic        s_tuser,   // kind [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // grant_offset [31:0], grant_size [63:32], status [65:64]
);

    cmd_t        cmd;
    stat_t       stat;
    logic [31:0] res_offset;
    logic [31:0] res_size;
    logic [1:0]  res_status;

    ffsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ffsa_dp #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_kind    (s_tuser),
        .in_size    (s_tdata[31:0]),
        .in_offset  (s_tdata[63:32]),
        .cmd        (cmd),
        .stat       (stat),
        .res_offset (res_offset),
        .res_size   (res_size),
        .res_status (res_status)
    );

    assign m_tdata = {6'b0, res_status, res_size, res_offset};

endmodule
